FILE: src/c3sf_pkg.sv
// Package for the 3x3 same-padding convolution block.
// Holds constants, codes, item and configuration types shared by the front, back and top modules.
// Depends on nothing.
package c3sf_pkg;

  localparam int DefMaxInChannels  = 64;
  localparam int DefMaxOutChannels = 64;
  localparam int DefMaxHeight      = 64;
  localparam int DefMaxWidth       = 64;
  localparam int KernelSize        = 3;
  localparam int Taps              = KernelSize * KernelSize;

  localparam int SampleW = 16;
  localparam int ProdW   = 32;
  localparam int SumW    = 42;
  localparam int CfgW    = 7;
  localparam int DimW    = 10;

  localparam logic [1:0] FUNC_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_LOAD_PIXEL  = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE     = 2'd2;

  localparam logic [1:0] CFG_INPUT_CHANNELS  = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_CHANNELS = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT    = 2'd2;
  localparam logic [1:0] CFG_IMAGE_WIDTH     = 2'd3;

  typedef enum logic [1:0] {
    KIND_WLOAD,
    KIND_PLOAD,
    KIND_CONV
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [5:0]         oc;
    logic [5:0]         ic;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [3:0]         tap;
    logic [SampleW-1:0] sample;
  } entry_t;

  typedef struct packed {
    logic [DimW-1:0] nin;
    logic [DimW-1:0] nout;
    logic [DimW-1:0] h;
    logic [DimW-1:0] w;
  } dims_t;

endpackage

FILE: src/c3sf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module c3sf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/c3sf_front.sv
// Front part: accepts input items, drops those without effect, and queues the rest.
// Depends on c3sf_pkg.
module c3sf_front #(
  parameter int MAX_IN_CHANNELS  = c3sf_pkg::DefMaxInChannels,
  parameter int MAX_OUT_CHANNELS = c3sf_pkg::DefMaxOutChannels,
  parameter int MAX_HEIGHT       = c3sf_pkg::DefMaxHeight,
  parameter int MAX_WIDTH        = c3sf_pkg::DefMaxWidth
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [1:0]                 in_func,
  input  logic [5:0]                 in_out_channel,
  input  logic [5:0]                 in_in_channel,
  input  logic [5:0]                 in_row,
  input  logic [5:0]                 in_col,
  input  logic [1:0]                 in_tap_row,
  input  logic [1:0]                 in_tap_col,
  input  logic [15:0]                in_sample,
  input  c3sf_pkg::dims_t            dims,
  output c3sf_pkg::entry_t           head,
  output logic                       head_valid,
  input  logic                       head_pop
);

  c3sf_pkg::entry_t q_r [2];
  c3sf_pkg::entry_t ent;
  logic             keep;
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push_q;

  always_comb begin
    ent.kind   = c3sf_pkg::KIND_CONV;
    ent.oc     = in_out_channel;
    ent.ic     = in_in_channel;
    ent.row    = in_row;
    ent.col    = in_col;
    ent.tap    = 4'({2'b0, in_tap_row} * 4'(c3sf_pkg::KernelSize)) + 4'(in_tap_col);
    ent.sample = in_sample;
    keep       = 1'b0;
    case (in_func)
      c3sf_pkg::FUNC_LOAD_WEIGHT: begin
        ent.kind = c3sf_pkg::KIND_WLOAD;
        keep = (int'(in_tap_row) < c3sf_pkg::KernelSize) &&
               (int'(in_tap_col) < c3sf_pkg::KernelSize) &&
               (int'(in_out_channel) < MAX_OUT_CHANNELS) &&
               (int'(in_in_channel) < MAX_IN_CHANNELS);
      end
      c3sf_pkg::FUNC_LOAD_PIXEL: begin
        ent.kind = c3sf_pkg::KIND_PLOAD;
        keep = (int'(in_in_channel) < MAX_IN_CHANNELS) &&
               (int'(in_row) < MAX_HEIGHT) && (int'(in_col) < MAX_WIDTH);
      end
      c3sf_pkg::FUNC_COMPUTE: begin
        keep = ({4'b0, in_out_channel} < dims.nout) &&
               ({4'b0, in_row} < dims.h) && ({4'b0, in_col} < dims.w);
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_full    = (cnt_r == 2'd2);
  assign push_q     = in_push && !in_full && keep;
  assign head       = q_r[rp_r];
  assign head_valid = (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (push_q) begin
      q_r[wp_r] <= ent;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_q) begin
        wp_r <= !wp_r;
      end
      if (head_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push_q) - 2'(head_pop);
    end
  end

endmodule

FILE: src/c3sf_back.sv
// Back part: performs loads into the stores and runs the multiply-accumulate
// sequence for compute items. Depends on c3sf_pkg and c3sf_ram.
module c3sf_back #(
  parameter int MAX_IN_CHANNELS  = c3sf_pkg::DefMaxInChannels,
  parameter int MAX_OUT_CHANNELS = c3sf_pkg::DefMaxOutChannels,
  parameter int MAX_HEIGHT       = c3sf_pkg::DefMaxHeight,
  parameter int MAX_WIDTH        = c3sf_pkg::DefMaxWidth
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  c3sf_pkg::entry_t            head,
  input  logic                        head_valid,
  output logic                        head_pop,
  input  c3sf_pkg::dims_t             dims,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic signed [41:0]          out_conv_sum,
  output logic [5:0]                  out_result_channel,
  output logic [5:0]                  out_result_row,
  output logic [5:0]                  out_result_col
);

  localparam int WDepth = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * c3sf_pkg::Taps;
  localparam int PDepth = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int WAW    = (WDepth > 1) ? $clog2(WDepth) : 1;
  localparam int PAW    = (PDepth > 1) ? $clog2(PDepth) : 1;
  localparam int ChW    = $clog2(MAX_IN_CHANNELS + 1);

  c3sf_pkg::state_t state_r, state_nxt;

  logic [5:0]   oc_r, row_r, col_r;
  logic [ChW-1:0] ch_r;
  logic [1:0]   kr_r, kc_r;
  logic         last_tap, last_ch;
  logic         issue, inb;
  int           y_i, x_i;
  logic         v1_r, v2_r;
  logic signed [c3sf_pkg::ProdW-1:0] prod_r;
  logic signed [c3sf_pkg::SumW-1:0]  acc_r;
  logic [15:0]  wq, pq;
  logic         wwe, pwe;
  logic [WAW-1:0] waddr, wraddr;
  logic [PAW-1:0] paddr, praddr;
  logic         out_valid_r;
  logic         start, finish;

  assign last_tap = (kr_r == 2'(c3sf_pkg::KernelSize - 1)) &&
                    (kc_r == 2'(c3sf_pkg::KernelSize - 1));
  assign last_ch  = (c3sf_pkg::DimW'(ch_r) == dims.nin - c3sf_pkg::DimW'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      c3sf_pkg::ST_IDLE: begin
        if (head_valid && head.kind == c3sf_pkg::KIND_CONV) begin
          state_nxt = (dims.nin == '0) ? c3sf_pkg::ST_DONE : c3sf_pkg::ST_RUN;
        end
      end
      c3sf_pkg::ST_RUN: begin
        if (last_tap && last_ch) begin
          state_nxt = c3sf_pkg::ST_DRAIN;
        end
      end
      c3sf_pkg::ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = c3sf_pkg::ST_DONE;
        end
      end
      c3sf_pkg::ST_DONE: begin
        if (!out_valid_r || out_pop) begin
          state_nxt = c3sf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = c3sf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_pop = 1'b0;
    wwe      = 1'b0;
    pwe      = 1'b0;
    start    = 1'b0;
    issue    = 1'b0;
    finish   = 1'b0;
    case (state_r)
      c3sf_pkg::ST_IDLE: begin
        head_pop = head_valid;
        wwe      = head_valid && head.kind == c3sf_pkg::KIND_WLOAD;
        pwe      = head_valid && head.kind == c3sf_pkg::KIND_PLOAD;
        start    = head_valid && head.kind == c3sf_pkg::KIND_CONV;
      end
      c3sf_pkg::ST_RUN:  issue  = 1'b1;
      c3sf_pkg::ST_DONE: finish = !out_valid_r || out_pop;
      default: ;
    endcase
  end

  always_comb begin
    y_i = int'(row_r) + 1 - int'(kr_r);
    x_i = int'(col_r) + 1 - int'(kc_r);
    inb = (y_i >= 0) && (y_i < int'(dims.h)) && (x_i >= 0) && (x_i < int'(dims.w));
    waddr  = WAW'((int'(head.oc) * MAX_IN_CHANNELS + int'(head.ic)) * c3sf_pkg::Taps +
                  int'(head.tap));
    paddr  = PAW'((int'(head.ic) * MAX_HEIGHT + int'(head.row)) * MAX_WIDTH +
                  int'(head.col));
    wraddr = WAW'((int'(oc_r) * MAX_IN_CHANNELS + int'(ch_r)) * c3sf_pkg::Taps +
                  int'(kr_r) * c3sf_pkg::KernelSize + int'(kc_r));
    praddr = PAW'((int'(ch_r) * MAX_HEIGHT + (inb ? y_i : 0)) * MAX_WIDTH +
                  (inb ? x_i : 0));
  end

  c3sf_ram #(.WIDTH(c3sf_pkg::SampleW), .DEPTH(WDepth)) u_wram (
    .clk(clk), .we(wwe), .waddr(waddr), .wdata(head.sample), .raddr(wraddr), .rdata(wq)
  );

  c3sf_ram #(.WIDTH(c3sf_pkg::SampleW), .DEPTH(PDepth)) u_pram (
    .clk(clk), .we(pwe), .waddr(paddr), .wdata(head.sample), .raddr(praddr), .rdata(pq)
  );

  always_ff @(posedge clk) begin
    prod_r <= $signed(wq) * $signed(pq);
    if (start) begin
      oc_r  <= head.oc;
      row_r <= head.row;
      col_r <= head.col;
      ch_r  <= '0;
      kr_r  <= '0;
      kc_r  <= '0;
      acc_r <= '0;
    end else begin
      if (issue) begin
        if (kc_r == 2'(c3sf_pkg::KernelSize - 1)) begin
          kc_r <= '0;
          if (kr_r == 2'(c3sf_pkg::KernelSize - 1)) begin
            kr_r <= '0;
            ch_r <= ch_r + ChW'(1);
          end else begin
            kr_r <= kr_r + 2'd1;
          end
        end else begin
          kc_r <= kc_r + 2'd1;
        end
      end
      if (v2_r) begin
        acc_r <= acc_r + c3sf_pkg::SumW'(prod_r);
      end
    end
    if (finish) begin
      out_conv_sum       <= acc_r;
      out_result_channel <= oc_r;
      out_result_row     <= row_r;
      out_result_col     <= col_r;
    end
    if (!rst_n) begin
      state_r     <= c3sf_pkg::ST_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue && inb;
      v2_r    <= v1_r;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty = !out_valid_r;

endmodule

FILE: src/conv3x3_same_forward_top.sv
// Top level of the 3x3 same-padding convolution block: configuration registers,
// front queue and back execution unit. Depends on c3sf_pkg, c3sf_front, c3sf_back.
//
// The back unit writes each load item into its store as it pops it. A compute
// item reads one filter tap and one pixel per cycle from the single read ports
// of the weight and pixel stores and accumulates their products; a compute with
// no input channels gives zero. A two-item queue lets loads and computes be pushed
// while the back unit is busy, and a finished result waits in an output register
// until popped. The stores are not cleared by reset; a compute must only touch
// entries already loaded.
module conv3x3_same_forward_top #(
  parameter int MAX_IN_CHANNELS  = c3sf_pkg::DefMaxInChannels,
  parameter int MAX_OUT_CHANNELS = c3sf_pkg::DefMaxOutChannels,
  parameter int MAX_HEIGHT       = c3sf_pkg::DefMaxHeight,
  parameter int MAX_WIDTH        = c3sf_pkg::DefMaxWidth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_func,
  input  logic [5:0]           in_out_channel,
  input  logic [5:0]           in_in_channel,
  input  logic [5:0]           in_row,
  input  logic [5:0]           in_col,
  input  logic [1:0]           in_tap_row,
  input  logic [1:0]           in_tap_col,
  input  logic signed [15:0]   in_sample,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic signed [41:0]   out_conv_sum,
  output logic [5:0]           out_result_channel,
  output logic [5:0]           out_result_row,
  output logic [5:0]           out_result_col,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [6:0]           cfg_data
);

  logic [6:0] nin_r, nout_r, h_r, w_r;
  c3sf_pkg::dims_t  dims;
  c3sf_pkg::entry_t head;
  logic             head_valid, head_pop;

  assign cfg_ready = 1'b1;

  function automatic logic [c3sf_pkg::DimW-1:0] sat(input logic [6:0] v, input int mx);
    logic [c3sf_pkg::DimW-1:0] ve;
    ve = c3sf_pkg::DimW'(v);
    return (int'(ve) > mx) ? c3sf_pkg::DimW'(mx) : ve;
  endfunction

  always_comb begin
    dims.nin  = sat(nin_r, MAX_IN_CHANNELS);
    dims.nout = sat(nout_r, MAX_OUT_CHANNELS);
    dims.h    = sat(h_r, MAX_HEIGHT);
    dims.w    = sat(w_r, MAX_WIDTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nin_r  <= 7'd1;
      nout_r <= 7'd1;
      h_r    <= 7'd64;
      w_r    <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        c3sf_pkg::CFG_INPUT_CHANNELS:  nin_r  <= cfg_data;
        c3sf_pkg::CFG_OUTPUT_CHANNELS: nout_r <= cfg_data;
        c3sf_pkg::CFG_IMAGE_HEIGHT:    h_r    <= cfg_data;
        c3sf_pkg::CFG_IMAGE_WIDTH:     w_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  c3sf_front #(
    .MAX_IN_CHANNELS(MAX_IN_CHANNELS), .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
    .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_func(in_func), .in_out_channel(in_out_channel), .in_in_channel(in_in_channel),
    .in_row(in_row), .in_col(in_col), .in_tap_row(in_tap_row), .in_tap_col(in_tap_col),
    .in_sample(in_sample), .dims(dims), .head(head), .head_valid(head_valid),
    .head_pop(head_pop)
  );

  c3sf_back #(
    .MAX_IN_CHANNELS(MAX_IN_CHANNELS), .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
    .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .head_valid(head_valid), .head_pop(head_pop),
    .dims(dims), .out_empty(out_empty), .out_pop(out_pop), .out_conv_sum(out_conv_sum),
    .out_result_channel(out_result_channel), .out_result_row(out_result_row),
    .out_result_col(out_result_col)
  );

endmodule
